### hw/rtl/pes_pkg.sv
// Shared widths, status codes and payload types of the periodic event scheduler.
package pes_pkg;

    localparam int ID_W     = 16;
    localparam int PERIOD_W = 16;
    localparam int STATUS_W = 2;
    localparam int ETIME_W  = 32;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [ETIME_W-1:0]  etime_t;

    // request kinds
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_POP      = 1'b1;

    // response status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_SATURATED = 2'd3;

endpackage

### hw/rtl/pes_req_if.sv
// Request channel: register or pop beats into the scheduler.
interface pes_req_if;
    logic              valid;
    logic              ready;
    logic              mode;
    pes_pkg::id_t      query_id;
    pes_pkg::period_t  period;

    modport source (output valid, output mode, output query_id, output period,
                    input ready);
    modport sink   (input valid, input mode, input query_id, input period,
                    output ready);
endinterface

### hw/rtl/pes_rsp_if.sv
// Response channel: one result beat per request.
interface pes_rsp_if;
    logic              valid;
    logic              ready;
    pes_pkg::status_t  status;
    pes_pkg::etime_t   event_time;
    pes_pkg::id_t      event_id;

    modport source (output valid, output status, output event_time, output event_id,
                    input ready);
    modport sink   (input valid, input status, input event_time, input event_id,
                    output ready);
endinterface

### hw/rtl/pes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/periodic_event_scheduler_core.sv
// Register: per heap level climbed, read the parent, then compare and write; the entry is
// written at the root, or by the compare that settles it lower. Pop: fetch the root, then
// per level descended read both children and compare; it is written at a leaf, or by the
// compare that settles it higher. One request in flight; ready returns in the same cycle
// the result is offered. Reset (rst_n, async, active low) clears the state, the entry
// count and the output valid flag; no RAM sweep, no wait.
module periodic_event_scheduler_core #(
    parameter int HEAP_DEPTH = 1024,
    parameter int TIME_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pes_req_if.sink   req,
    pes_rsp_if.source rsp
);

    localparam int AW = $clog2(HEAP_DEPTH);      // heap address
    localparam int CW = $clog2(HEAP_DEPTH + 1);  // entry count
    localparam int IW = AW + 2;                  // child index, may pass the end
    localparam int EW = TIME_BITS + pes_pkg::ID_W + pes_pkg::PERIOD_W;

    // state codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CHK  = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_POP_TOP = 4'd3;
    localparam logic [3:0] S_DN_L    = 4'd4;
    localparam logic [3:0] S_DN_R    = 4'd5;
    localparam logic [3:0] S_DN_CMP  = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    // entry word is {time, id, period}: one unsigned compare orders entries
    logic [3:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [EW-1:0]          cur_reg, cur_next;
    logic [EW-1:0]          lhold_reg, lhold_next;
    logic                   rvalid_reg, rvalid_next;
    pes_pkg::status_t       res_status_reg, res_status_next;
    pes_pkg::etime_t        res_time_reg, res_time_next;
    pes_pkg::id_t           res_id_reg, res_id_next;
    logic                   out_valid_reg, out_valid_next;
    pes_pkg::status_t       out_status_reg, out_status_next;
    pes_pkg::etime_t        out_time_reg, out_time_next;
    pes_pkg::id_t           out_id_reg, out_id_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;

    logic                   req_fire;
    logic [AW-1:0]          parent_idx;
    logic [IW-1:0]          left_idx;
    logic [IW-1:0]          right_idx;
    logic [IW-1:0]          count_ext;
    logic [TIME_BITS-1:0]   top_time;
    logic [TIME_BITS:0]     time_sum;
    logic [TIME_BITS-1:0]   next_time;
    logic [63:0]            top_time_ext;
    logic [EW-1:0]          best_entry;
    logic [1:0]             best_sel;
    logic                   out_free;

    pes_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign req_fire       = req.valid && req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.event_time = out_time_reg;
    assign rsp.event_id   = out_id_reg;
    assign out_free       = !out_valid_reg || rsp.ready;

    // heap index arithmetic
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = IW'({pos_reg, 1'b1});
    assign right_idx  = left_idx + IW'(1);
    assign count_ext  = IW'(count_reg);

    // saturating reschedule of the root
    assign top_time     = ram_rdata[EW-1 -: TIME_BITS];
    assign time_sum     = {1'b0, top_time} + (TIME_BITS+1)'(ram_rdata[pes_pkg::PERIOD_W-1:0]);
    assign next_time    = time_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : time_sum[TIME_BITS-1:0];
    assign top_time_ext = 64'(top_time);

    // smallest of hole entry, left child and (if present) right child
    always_comb
    begin
        best_entry = cur_reg;
        best_sel   = 2'd0;
        if (lhold_reg < best_entry)
        begin
            best_entry = lhold_reg;
            best_sel   = 2'd1;
        end
        if (rvalid_reg && (ram_rdata < best_entry))
        begin
            best_entry = ram_rdata;
            best_sel   = 2'd2;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        lhold_next      = lhold_reg;
        rvalid_next     = rvalid_reg;
        res_status_next = res_status_reg;
        res_time_next   = res_time_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_time_next   = out_time_reg;
        out_id_next     = out_id_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // root address is presented here so a pop sees it next cycle
                if (req_fire)
                begin
                    res_status_next = pes_pkg::ST_OK;
                    res_time_next   = '0;
                    res_id_next     = '0;
                    if (req.mode == pes_pkg::MODE_REGISTER)
                    begin
                        if (count_reg == CW'(HEAP_DEPTH))
                        begin
                            res_status_next = pes_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cur_next   = {TIME_BITS'(req.period), req.query_id, req.period};
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_CHK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = pes_pkg::ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POP_TOP;
                    end
                end
            end

            S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                // move the parent down into the hole, or settle here
                ram_we = 1'b1;
                if (cur_reg < ram_rdata)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_POP_TOP:
            begin
                res_time_next   = top_time_ext[31:0];
                res_id_next     = ram_rdata[pes_pkg::PERIOD_W +: pes_pkg::ID_W];
                res_status_next = time_sum[TIME_BITS] ? pes_pkg::ST_SATURATED
                                                      : pes_pkg::ST_OK;
                cur_next        = {next_time, ram_rdata[pes_pkg::ID_W+pes_pkg::PERIOD_W-1:0]};
                pos_next        = '0;
                state_next      = S_DN_L;
            end

            S_DN_L:
            begin
                if (left_idx >= count_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                lhold_next  = ram_rdata;
                rvalid_next = (right_idx < count_ext);
                ram_raddr   = right_idx[AW-1:0];
                state_next  = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                // pull the smaller child up, or drop the entry into the hole
                ram_we    = 1'b1;
                ram_wdata = best_entry;
                case (best_sel)
                    2'd1:
                    begin
                        pos_next   = left_idx[AW-1:0];
                        state_next = S_DN_L;
                    end
                    2'd2:
                    begin
                        pos_next   = right_idx[AW-1:0];
                        state_next = S_DN_L;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_time_next   = res_time_reg;
                    out_id_next     = res_id_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        lhold_reg      <= lhold_next;
        rvalid_reg     <= rvalid_next;
        res_status_reg <= res_status_next;
        res_time_reg   <= res_time_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_time_reg   <= out_time_next;
        out_id_reg     <= out_id_next;
    end

endmodule

### hw/rtl/pes_checker.sv
// Port-level checks of the scheduler, bound to the top level.
module pes_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input pes_pkg::status_t rsp_status,
    input pes_pkg::etime_t  rsp_event_time,
    input pes_pkg::id_t     rsp_event_id
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    // requests taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (req_beat && !rsp_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_beat && !req_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response withdrawn while stalled");

    // every response answers an earlier request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("response without an outstanding request");

    // at most one request in work and one answer waiting
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !req_ready)
        else $error("request taken beyond output stage depth");

    // empty and full reports carry no event
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == pes_pkg::ST_EMPTY || rsp_status == pes_pkg::ST_FULL)
        |-> (rsp_event_time == '0) && (rsp_event_id == '0))
        else $error("error status with event payload");

endmodule

bind periodic_event_scheduler_core pes_checker u_pes_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_event_time (rsp.event_time),
    .rsp_event_id   (rsp.event_id)
);

### dv/tb_periodic_event_scheduler_core.sv
// Testbench for the periodic event scheduler: heap ordering, ties, zero periods, empty status.
`timescale 1ns / 1ps

module tb_periodic_event_scheduler_core;

    localparam int DEPTH          = 1024;
    localparam int TBITS          = 32;
    localparam logic [63:0] TIME_CEIL = (64'd1 << TBITS) - 64'd1;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RANDOM_BEATS   = 420;

    typedef struct {
        pes_pkg::status_t st;
        pes_pkg::etime_t  tm;
        pes_pkg::id_t     id;
    } event_beat_t;

    typedef struct {
        logic             mode;
        pes_pkg::id_t     id;
        pes_pkg::period_t per;
    } req_beat_t;

    // Scoreboard: own copy of the timer heap, predicts each response beat
    class event_order_board;
        logic [63:0]      fire_at [DEPTH];
        pes_pkg::id_t     qid     [DEPTH];
        pes_pkg::period_t every   [DEPTH];
        int               count      = 0;
        int               accepted   = 0;
        int               mismatches = 0;
        event_beat_t      due_events [$];

        // ordering: time, then id, then period
        function bit earlier(int a, int b);
            if (fire_at[a] != fire_at[b])
                return fire_at[a] < fire_at[b];
            if (qid[a] != qid[b])
                return qid[a] < qid[b];
            return every[a] < every[b];
        endfunction

        function void swap_slots(int a, int b);
            logic [63:0]      t;
            pes_pkg::id_t     i;
            pes_pkg::period_t p;
            t = fire_at[a]; fire_at[a] = fire_at[b]; fire_at[b] = t;
            i = qid[a];     qid[a]     = qid[b];     qid[b]     = i;
            p = every[a];   every[a]   = every[b];   every[b]   = p;
        endfunction

        function void note_request(logic mode, pes_pkg::id_t id, pes_pkg::period_t per);
            event_beat_t due;
            int          pos;
            int          par;
            int          l;
            int          r;
            int          best;
            bit          settled;
            logic [63:0] t;
            due.st = pes_pkg::ST_OK;
            due.tm = '0;
            due.id = '0;
            accepted++;
            if (mode == pes_pkg::MODE_REGISTER)
            begin
                if (count >= DEPTH)
                begin
                    due.st = pes_pkg::ST_FULL;
                end
                else
                begin
                    fire_at[count] = 64'(per) & TIME_CEIL;
                    qid[count]     = id;
                    every[count]   = per;
                    pos = count;
                    count++;
                    // climb towards the root
                    while (pos > 0)
                    begin
                        par = (pos - 1) / 2;
                        if (!earlier(pos, par))
                            break;
                        swap_slots(pos, par);
                        pos = par;
                    end
                end
            end
            else if (count == 0)
            begin
                due.st = pes_pkg::ST_EMPTY;
            end
            else
            begin
                t      = fire_at[0];
                due.tm = t[pes_pkg::ETIME_W-1:0];
                due.id = qid[0];
                if (TIME_CEIL - t < 64'(every[0]))
                begin
                    fire_at[0] = TIME_CEIL;
                    due.st     = pes_pkg::ST_SATURATED;
                end
                else
                begin
                    fire_at[0] = t + 64'(every[0]);
                end
                // push the rescheduled root down
                pos     = 0;
                settled = 1'b0;
                while (!settled)
                begin
                    l    = 2 * pos + 1;
                    r    = l + 1;
                    best = pos;
                    if (l < count && earlier(l, best))
                        best = l;
                    if (r < count && earlier(r, best))
                        best = r;
                    if (best == pos)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
            end
            due_events.push_back(due);
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_event(pes_pkg::status_t st, pes_pkg::etime_t tm,
                                  pes_pkg::id_t id);
            event_beat_t due;
            if (due_events.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response, expected none, got %0d %0d %0d",
                         $time, st, tm, id);
            end
            else
            begin
                due = due_events.pop_front();
                compare_field("status", due.st, st);
                compare_field("event_time", due.tm, tm);
                compare_field("event_id", due.id, id);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pes_req_if req_ch ();
    pes_rsp_if rsp_ch ();

    periodic_event_scheduler_core #(
        .HEAP_DEPTH (DEPTH),
        .TIME_BITS  (TBITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    event_order_board board = new;
    req_beat_t        stim_q [$];
    int               beats_queued = 0;
    bit               no_idle      = 1'b0;
    int               idle_cycles  = 0;

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Gap length: mostly short, a few long, with bursts of no gap at all
    function automatic int pick_gap(ref int burst);
        int roll;
        if (no_idle)
            return 0;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 82)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver: presents queued beats, with a random idle gap, possibly none, between them
    initial
    begin
        req_beat_t b;
        int        send_gap;
        int        send_burst;
        send_gap   = 0;
        send_burst = 0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= pes_pkg::MODE_REGISTER;
        req_ch.query_id <= '0;
        req_ch.period   <= '0;
        forever
        begin
            @(posedge clk);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (stim_q.size() != 0)
                begin
                    b = stim_q.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.mode     <= b.mode;
                    req_ch.query_id <= b.id;
                    req_ch.period   <= b.per;
                    send_gap = pick_gap(send_burst);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response side: ready high for runs, low for stalls of random length
    initial
    begin
        int hold;
        int gap;
        int recv_burst;
        hold       = 0;
        recv_burst = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                gap = pick_gap(recv_burst);
                if (gap == 0)
                begin
                    rsp_ch.ready <= 1'b1;
                    hold = no_idle ? 0 : $urandom_range(0, 6);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    hold = gap - 1;
                end
            end
        end
    end

    // Beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.mode, req_ch.query_id, req_ch.period);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_event(rsp_ch.status, rsp_ch.event_time, rsp_ch.event_id);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_beat(input logic mode, input pes_pkg::id_t id,
                              input pes_pkg::period_t per);
        req_beat_t b;
        b.mode = mode;
        b.id   = id;
        b.per  = per;
        while (stim_q.size() >= 2)
            @(posedge clk);
        stim_q.push_back(b);
        beats_queued++;
    endtask

    // Pops carry random values in the ignored fields
    task automatic queue_pop();
        queue_beat(pes_pkg::MODE_POP, pes_pkg::id_t'($urandom), pes_pkg::period_t'($urandom));
    endtask

    // Wait until every queued beat is taken and answered
    task automatic drain();
        while (board.accepted != beats_queued || board.due_events.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int               roll;
        int               pick;
        pes_pkg::id_t     id;
        pes_pkg::period_t per;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap, then a single query at the largest period
        queue_beat(pes_pkg::MODE_POP, 16'hFFFF, 16'hFFFF);
        queue_beat(pes_pkg::MODE_REGISTER, 16'hFFFF, 16'hFFFF);
        queue_pop();
        queue_pop();
        drain();

        // ties on time, on id, identical entries, id extremes, back to back
        no_idle = 1'b1;
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0000, 16'h0001);
        queue_beat(pes_pkg::MODE_REGISTER, 16'hFFFF, 16'h0001);
        queue_beat(pes_pkg::MODE_REGISTER, 16'h5555, 16'h0002);
        queue_beat(pes_pkg::MODE_REGISTER, 16'hAAAA, 16'h0002);
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0100, 16'h0003);
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0100, 16'h0003);
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0100, 16'h0006);
        repeat (10) queue_pop();
        drain();
        no_idle = 1'b0;

        // random mix, small id and period pools to force ties
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == RANDOM_BEATS / 2)
                drain();
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
                id = pes_pkg::id_t'($urandom_range(0, 7));
            else
                id = pes_pkg::id_t'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                per = pes_pkg::period_t'($urandom_range(1, 16));
            else if (pick == 3)
                per = ($urandom_range(0, 1) == 0) ? 16'h0001 : 16'hFFFF;
            else
                per = pes_pkg::period_t'($urandom_range(1, 65535));
            if (roll < 40)
                queue_beat(pes_pkg::MODE_REGISTER, id, per);
            else
                queue_pop();
        end
        drain();

        // zero period queries stay at the front of the heap
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0042, 16'h0000);
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0041, 16'h0000);
        repeat (4) queue_beat(pes_pkg::MODE_REGISTER, pes_pkg::id_t'($urandom),
                              pes_pkg::period_t'($urandom));
        repeat (6) queue_pop();
        queue_beat(pes_pkg::MODE_REGISTER, 16'h0000, 16'h0000);
        queue_pop();

        drain();
        repeat (64) @(posedge clk);
        if (board.mismatches == 0 && board.due_events.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0t: %0d mismatches, %0d responses outstanding", $time,
                     board.mismatches, board.due_events.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/pes_pkg.sv
hw/rtl/pes_req_if.sv
hw/rtl/pes_rsp_if.sv
hw/rtl/pes_ram.sv
hw/rtl/periodic_event_scheduler_core.sv
hw/rtl/pes_checker.sv
dv/tb_periodic_event_scheduler_core.sv
